>>> rtl/pi_phase_angle_controller_assert.svh
// Assertion macros shared by the PI phase-angle controller RTL.
`ifndef PI_PHASE_ANGLE_CONTROLLER_ASSERT_SVH
`define PI_PHASE_ANGLE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define PIPA_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pipa: assertion failed");

// Check that a condition implies another in the same cycle.
`define PIPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipa: implication failed");

// Check that a condition implies another in the next cycle.
`define PIPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipa: next-cycle implication failed");

`else

`define PIPA_ASSERT(lbl, expr)
`define PIPA_ASSERT_IMP(lbl, ante, cons)
`define PIPA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/pipa_pkg.sv
// Package: constants, register codes and types of the PI phase-angle controller.
package pipa_pkg;

    localparam int ErrLimit    = 500;
    localparam int DriveMax    = 900;
    localparam int DelayBase   = 10000;
    localparam int PreloadMax  = 64335;
    localparam int PreloadMin  = 58035;
    localparam int PreloadBase = 65535 - DelayBase;
    localparam int BandLimit   = 60;
    localparam int IntegPreset = 10;

    // floor(m/100) == (m * Recip100) >> Recip100Shift for every 16-bit m
    localparam int Recip100Shift = 23;
    localparam int Recip100      = (1 << Recip100Shift) / 100 + 1;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 7;
    localparam logic [CfgIdxW-1:0] RegPropGain  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegIntegGain = CfgIdxW'(1);

    localparam int IntegW = 12;   // integrator spans -635..1535
    localparam int TermW  = 11;   // signed P term and integral increment
    localparam int SumW   = 13;

    typedef struct packed {
        logic [9:0]  drive;
        logic [13:0] firing_delay;
        logic [15:0] timer_preload;
    } result_t;

endpackage

>>> rtl/pipa_div100.sv
// Truncating divide by 100 of a 16-bit magnitude through a reciprocal product.
module pipa_div100
    import pipa_pkg::*;
(
    input  logic [15:0] dividend,
    output logic [9:0]  quotient
);

    logic [32:0] product;

    assign product  = {17'b0, dividend} * 33'(Recip100);
    assign quotient = product[Recip100Shift +: 10];

endmodule

>>> rtl/pipa_update.sv
// Integrator update with anti-windup saturation and drive-to-timing conversion.
module pipa_update
    import pipa_pkg::*;
(
    input  logic signed [IntegW-1:0] integ,
    input  logic signed [TermW-1:0]  p_term,
    input  logic signed [TermW-1:0]  i_incr,
    input  logic                     inhibit,
    input  logic                     zc_fault,
    output logic signed [IntegW-1:0] integ_next,
    output result_t                  result
);

    logic signed [IntegW-1:0] base;
    logic signed [SumW-1:0]   ri;
    logic signed [SumW-1:0]   sum;
    logic signed [IntegW-1:0] p_ext;
    logic signed [IntegW-1:0] integ_sat;
    logic [9:0]               drive;
    logic [13:0]              ten_drive;
    logic [15:0]              preload_raw;

    // Inhibit presets the integrator before the update
    assign base  = inhibit ? IntegW'(IntegPreset) : integ;
    assign ri    = SumW'(base) + SumW'(i_incr);
    assign sum   = ri + SumW'(p_term);
    assign p_ext = IntegW'(p_term);

    always_comb
    begin
        priority if (sum > $signed(SumW'(DriveMax)))
        begin
            integ_sat = IntegW'(DriveMax) - p_ext;
            drive     = 10'(DriveMax);
        end
        else if (sum < $signed(SumW'(0)))
        begin
            integ_sat = -p_ext;
            drive     = '0;
        end
        else
        begin
            integ_sat = ri[IntegW-1:0];
            drive     = sum[9:0];
        end
    end

    assign integ_next = zc_fault ? '0 : integ_sat;

    assign ten_drive   = {1'b0, drive, 3'b0} + {3'b0, drive, 1'b0};
    assign preload_raw = 16'(PreloadBase) + {2'b0, ten_drive};

    always_comb
    begin
        result.drive        = drive;
        result.firing_delay = 14'(DelayBase) - ten_drive;
        priority if (preload_raw > 16'(PreloadMax))
            result.timer_preload = 16'(PreloadMax);
        else if (preload_raw < 16'(PreloadMin))
            result.timer_preload = 16'(PreloadMin);
        else
            result.timer_preload = preload_raw;
    end

endmodule

>>> rtl/pi_phase_angle_controller.sv
// Top level of the PI phase-angle controller: pipeline, gains and integrator state.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------------
//   sample   | sample_valid, sample_stall | setpoint, measured, inhibit, zero_cross_fault
//   result   | result_valid, result_stall | drive, firing_delay, timer_preload, in_band
//   config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One sample per cycle while the result side does not stall, through four register stages:
// stages 1 to 3 and the output register. The integrator recurrence closes in the
// last stage alone, since the P term and integral increment depend only on the sample.
// Reset clears all valid flags, loads both gains with 2 and presets the integrator to 10.
// A stall on the result side fills the stages behind it one by one; the sample side
// stalls only once all four stages hold an item. cfg_ready is always high.
module pi_phase_angle_controller
    import pipa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [9:0]          setpoint,
    input  logic [9:0]          measured,
    input  logic                inhibit,
    input  logic                zero_cross_fault,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [9:0]          drive,
    output logic [13:0]         firing_delay,
    output logic [15:0]         timer_preload,
    output logic                in_band,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

`include "pi_phase_angle_controller_assert.svh"

    // ------------------------------------------------------------------
    // Gain registers
    // ------------------------------------------------------------------
    logic [6:0] prop_gain_reg;
    logic [4:0] integ_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= 7'd2;
            integ_gain_reg <= 5'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                RegPropGain:  prop_gain_reg  <= cfg_data[6:0];
                RegIntegGain: integ_gain_reg <= cfg_data[4:0];
                default:      ; // drop writes to unknown registers
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage advances when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic result_valid_reg;
    logic out_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;

    assign out_ready    = !result_valid_reg || !result_stall;
    assign s3_ready     = !s3_valid_reg || out_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= sample_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                result_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, inhibit applied on transfer
    // ------------------------------------------------------------------
    logic [9:0] s1_sp_reg;
    logic [9:0] s1_pv_reg;
    logic       s1_inh_reg;
    logic       s1_zcf_reg;

    always_ff @(posedge clk)
    begin
        if (sample_valid && s1_ready)
        begin
            s1_sp_reg  <= inhibit ? '0 : setpoint;
            s1_pv_reg  <= inhibit ? '0 : measured;
            s1_inh_reg <= inhibit;
            s1_zcf_reg <= zero_cross_fault;
        end
    end

    // Error magnitude, clamped symmetrically, and the two gain products
    logic signed [10:0] diff;
    logic [9:0]         abs_diff;
    logic [8:0]         err_mag;
    logic [6:0]         ki_times3;
    logic [15:0]        p_prod_next;
    logic [15:0]        i_prod_next;
    logic               band_next;

    assign diff      = $signed({1'b0, s1_sp_reg}) - $signed({1'b0, s1_pv_reg});
    assign abs_diff  = diff[10] ? 10'(-diff) : diff[9:0];
    assign err_mag   = (abs_diff >= 10'(ErrLimit)) ? 9'(ErrLimit) : abs_diff[8:0];
    assign ki_times3 = {2'b0, integ_gain_reg} + {1'b0, integ_gain_reg, 1'b0};
    assign p_prod_next = {7'b0, err_mag} * {9'b0, prop_gain_reg};
    assign i_prod_next = {7'b0, err_mag} * {9'b0, ki_times3};
    assign band_next   = abs_diff < 10'(BandLimit);

    // ------------------------------------------------------------------
    // Stage 2: product magnitudes and error sign
    // ------------------------------------------------------------------
    logic [15:0] s2_p_prod_reg;
    logic [15:0] s2_i_prod_reg;
    logic        s2_neg_reg;
    logic        s2_band_reg;
    logic        s2_inh_reg;
    logic        s2_zcf_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_p_prod_reg <= p_prod_next;
            s2_i_prod_reg <= i_prod_next;
            s2_neg_reg    <= diff[10];
            s2_band_reg   <= band_next;
            s2_inh_reg    <= s1_inh_reg;
            s2_zcf_reg    <= s1_zcf_reg;
        end
    end

    // Divide magnitudes by 100, then restore the sign: truncation toward zero
    logic [9:0]              p_quot;
    logic [9:0]              i_quot;
    logic signed [TermW-1:0] p_term_next;
    logic signed [TermW-1:0] i_incr_next;

    pipa_div100 u_div_p
    (
        .dividend (s2_p_prod_reg),
        .quotient (p_quot)
    );

    pipa_div100 u_div_i
    (
        .dividend (s2_i_prod_reg),
        .quotient (i_quot)
    );

    assign p_term_next = s2_neg_reg ? -$signed({1'b0, p_quot}) : $signed({1'b0, p_quot});
    assign i_incr_next = s2_neg_reg ? -$signed({1'b0, i_quot}) : $signed({1'b0, i_quot});

    // ------------------------------------------------------------------
    // Stage 3: signed terms
    // ------------------------------------------------------------------
    logic signed [TermW-1:0] s3_p_reg;
    logic signed [TermW-1:0] s3_i_reg;
    logic                    s3_band_reg;
    logic                    s3_inh_reg;
    logic                    s3_zcf_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_p_reg    <= p_term_next;
            s3_i_reg    <= i_incr_next;
            s3_band_reg <= s2_band_reg;
            s3_inh_reg  <= s2_inh_reg;
            s3_zcf_reg  <= s2_zcf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: integrator recurrence and result register
    // ------------------------------------------------------------------
    logic signed [IntegW-1:0] integrator_reg;
    logic signed [IntegW-1:0] integrator_next;
    result_t                  result_next;
    result_t                  result_reg;
    logic                     in_band_reg;
    logic                     advance;

    pipa_update u_update
    (
        .integ      (integrator_reg),
        .p_term     (s3_p_reg),
        .i_incr     (s3_i_reg),
        .inhibit    (s3_inh_reg),
        .zc_fault   (s3_zcf_reg),
        .integ_next (integrator_next),
        .result     (result_next)
    );

    assign advance = s3_valid_reg && out_ready;

    // Advance the integrator only when its item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integrator_reg <= IntegW'(IntegPreset);
        else if (advance)
            integrator_reg <= integrator_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg  <= result_next;
            in_band_reg <= s3_band_reg;
        end
    end

    assign drive         = result_reg.drive;
    assign firing_delay  = result_reg.firing_delay;
    assign timer_preload = result_reg.timer_preload;
    assign in_band       = in_band_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PIPA_ASSERT(a_integ_range, integrator_reg >= -12'sd635 && integrator_reg <= 12'sd1535)
    `PIPA_ASSERT_IMP(a_drive_max, result_valid_reg, drive <= 10'(DriveMax))
    `PIPA_ASSERT_IMP(a_preload_range, result_valid_reg, timer_preload >= 16'(PreloadMin) && timer_preload <= 16'(PreloadMax))
    `PIPA_ASSERT_NXT(a_fault_clears, advance && s3_zcf_reg, integrator_reg == '0)
    `PIPA_ASSERT_IMP(a_full_stalls, result_valid_reg && result_stall && s1_valid_reg && s2_valid_reg && s3_valid_reg, sample_stall)

endmodule

>>> tb/sv/pi_phase_angle_controller_test.sv
// Self-checking testbench of the PI phase-angle controller: predicted drive and firing values.
module pi_phase_angle_controller_test
    import pipa_pkg::*;
();

    localparam int GainReset     = 2;     // both gains come out of reset at 2
    localparam int PipeDepth     = 4;     // register stages between sample and result
    localparam int WatchdogLimit = 2000;  // cycles without any transfer before giving up
    localparam int PhaseItems    = 270;   // random samples per gain setting

    // Indexes outside the register map; writes to them must leave both gains alone.
    localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);

    // One predicted result, at the widths of the result ports.
    typedef struct {
        logic [9:0]  drive;
        logic [13:0] delay;
        logic [15:0] preload;
        logic        band;
    } firing_t;

    // Scoreboard: its own copy of the gains and the integrator, plus the queue of
    // results still owed by the block.
    class drive_scoreboard;
        int      kp;
        int      ki;
        int      integ;
        int      errors;
        firing_t pending_firing[$];

        function new();
            kp     = GainReset;
            ki     = GainReset;
            integ  = IntegPreset;
            errors = 0;
        endfunction

        function void set_gain(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            unique case (idx)
                RegPropGain:  kp = int'(data);
                RegIntegGain: ki = int'(data[4:0]);
                default: ;
            endcase
        endfunction

        // Run one PI update on an accepted sample and queue the result it must give.
        function void note_sample(int sp, int pv, bit inh, bit zc);
            int      err;
            int      p_term;
            int      i_next;
            int      sum;
            int      drv;
            int      dly;
            int      pre;
            int      gap;
            firing_t want;
            if (inh)
            begin
                sp    = 0;
                pv    = 0;
                integ = IntegPreset;
            end
            err = sp - pv;
            if (err <= -ErrLimit)
                err = -ErrLimit;
            else if (err >= ErrLimit)
                err = ErrLimit;
            // int division truncates toward zero, as the block must
            p_term = err * kp / 100;
            i_next = ki * err * 3 / 100 + integ;
            sum    = p_term + i_next;
            // back-calculate the integrator whenever the output clips
            if (sum > DriveMax)
            begin
                integ = DriveMax - p_term;
                drv   = DriveMax;
            end
            else if (sum < 0)
            begin
                integ = -p_term;
                drv   = 0;
            end
            else
            begin
                integ = i_next;
                drv   = sum;
            end
            if (zc)
                integ = 0;
            dly = DelayBase - 10 * drv;
            pre = 65535 - dly;
            if (pre > PreloadMax)
                pre = PreloadMax;
            if (pre < PreloadMin)
                pre = PreloadMin;
            gap = (sp > pv) ? sp - pv : pv - sp;
            want.drive   = drv[9:0];
            want.delay   = dly[13:0];
            want.preload = pre[15:0];
            want.band    = (gap < BandLimit);
            pending_firing.push_back(want);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // Match a result transfer against the oldest prediction.
        function void check_firing(logic [9:0] drv, logic [13:0] dly, logic [15:0] pre,
                                   logic band);
            firing_t want;
            if (pending_firing.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual drive %0d",
                         $time, drv);
                return;
            end
            want = pending_firing.pop_front();
            compare_field("drive", want.drive, drv);
            compare_field("firing_delay", want.delay, dly);
            compare_field("timer_preload", want.preload, pre);
            compare_field("in_band", want.band, band);
        endfunction
    endclass

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                sample_valid     = 1'b0;
    logic                sample_stall;
    logic [9:0]          setpoint         = '0;
    logic [9:0]          measured         = '0;
    logic                inhibit          = 1'b0;
    logic                zero_cross_fault = 1'b0;
    logic                result_valid;
    logic                result_stall     = 1'b0;
    logic [9:0]          drive;
    logic [13:0]         firing_delay;
    logic [15:0]         timer_preload;
    logic                in_band;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index        = '0;
    logic [CfgDataW-1:0] cfg_data         = '0;

    drive_scoreboard sb = new();

    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_tick  = 0;
    int quiet_count = 0;
    bit draining    = 1'b0;

    always #6 clk = ~clk;

    pi_phase_angle_controller dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .setpoint         (setpoint),
        .measured         (measured),
        .inhibit          (inhibit),
        .zero_cross_fault (zero_cross_fault),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .drive            (drive),
        .firing_delay     (firing_delay),
        .timer_preload    (timer_preload),
        .in_band          (in_band),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Receiver: switch at random between stall styles - none at all, light random,
    // heavy random and a fixed duty pattern. Drop all stalls while draining so that
    // late or extra results show up.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        if (draining)
            result_stall <= 1'b0;
        else
            unique case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 9) < 3);
                2: result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ((stall_tick % 11) < 4);
            endcase
    end

    // Check every result transfer as it happens.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_firing(drive, firing_delay, timer_preload, in_band);
    end

    // Watchdog: count cycles in which no transfer happens on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else if (quiet_count >= WatchdogLimit)
        begin
            $display("[pi_phase_angle_controller] ERROR");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // Hold the sample channel idle for a number of cycles.
    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
        end
    endtask

    // Offer one sample and hold it until the transfer; valid stays high across
    // back-to-back samples within a burst, and a gap opens between most bursts.
    task automatic send_sample(logic [9:0] sp, logic [9:0] pv, logic inh, logic zc);
        if (burst_left == 0)
        begin
            // a quarter of the bursts follow straight on with no gap
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 15));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        sample_valid     = 1'b1;
        setpoint         = sp;
        measured         = pv;
        inhibit          = inh;
        zero_cross_fault = zc;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(int'(sp), int'(pv), inh, zc);
    endtask

    // Write one register and mirror the write into the scoreboard on the transfer.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_gain(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_firing.size() != 0)
            @(posedge clk);
    endtask

    // Change gains only with the pipeline empty: drain, then let the stages settle.
    task automatic set_gains(logic [CfgDataW-1:0] kp, logic [CfgDataW-1:0] ki);
        pause_sender(1);
        wait_drained();
        repeat (PipeDepth + 2) @(posedge clk);
        write_reg(RegPropGain, kp);
        write_reg(RegIntegGain, ki);
    endtask

    // Random traffic in runs around a held setpoint, so that the integrator
    // settles and walks rather than sitting clipped; some samples wander off and
    // a few sit at the range ends.
    task automatic random_runs(int count);
        int base;
        int run_len;
        int pick;
        int sp;
        int pv;
        while (count > 0)
        begin
            base    = $urandom_range(0, 1023);
            run_len = $urandom_range(4, 40);
            for (int k = 0; k < run_len && count > 0; k++)
            begin
                pick = $urandom_range(0, 19);
                sp   = base;
                if (pick < 10)
                begin
                    pv = base + $urandom_range(0, 160) - 80;
                    if (pv < 0)
                        pv = 0;
                    if (pv > 1023)
                        pv = 1023;
                end
                else if (pick < 15)
                    pv = $urandom_range(0, 1023);
                else if (pick < 18)
                begin
                    sp = $urandom_range(0, 1023);
                    pv = $urandom_range(0, 1023);
                end
                else
                begin
                    sp = $urandom_range(0, 1) ? 1023 : 0;
                    pv = $urandom_range(0, 1) ? 1023 : 0;
                end
                send_sample(sp[9:0], pv[9:0], $urandom_range(0, 14) == 0,
                            $urandom_range(0, 9) == 0);
                count--;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset gains: zero error, clamped errors both ways, the band edge
        // on each side, inhibit with full-scale inputs, and a fault mid-range.
        send_sample(10'd0, 10'd0, 1'b0, 1'b0);
        send_sample(10'd1023, 10'd0, 1'b0, 1'b0);
        send_sample(10'd0, 10'd1023, 1'b0, 1'b0);
        send_sample(10'd500, 10'd440, 1'b0, 1'b0);
        send_sample(10'd500, 10'd441, 1'b0, 1'b0);
        send_sample(10'd441, 10'd500, 1'b0, 1'b0);
        send_sample(10'd1023, 10'd1023, 1'b1, 1'b0);
        send_sample(10'd300, 10'd200, 1'b0, 1'b1);

        // Directed, top of the gain range: drive into the upper clip, fault there,
        // then into the lower clip, inhibit together with a fault, the error limit
        // exactly and one past it, and truncation of tiny terms toward zero.
        set_gains(7'd64, 7'd20);
        repeat (4) send_sample(10'd1023, 10'd0, 1'b0, 1'b0);
        send_sample(10'd1023, 10'd0, 1'b0, 1'b1);
        repeat (3) send_sample(10'd0, 10'd1023, 1'b0, 1'b0);
        send_sample(10'd0, 10'd1023, 1'b1, 1'b1);
        send_sample(10'd523, 10'd23, 1'b0, 1'b0);
        send_sample(10'd23, 10'd523, 1'b0, 1'b0);
        send_sample(10'd524, 10'd23, 1'b0, 1'b0);
        send_sample(10'd513, 10'd512, 1'b0, 1'b0);
        send_sample(10'd512, 10'd513, 1'b0, 1'b0);

        // Random phases, each under its own gain setting: both extremes of the
        // range, values past it, the reset values and random picks. Writes to the
        // spare indexes go in between and must change nothing.
        for (int phase = 0; phase < 7; phase++)
        begin
            unique case (phase)
                0: set_gains(7'd0, 7'd0);
                1:
                begin
                    set_gains(7'h7f, 7'h7f);
                    write_reg(RegSpareA, 7'h7f);
                end
                2: set_gains(7'd64, 7'd20);
                3:
                begin
                    set_gains(7'd1, 7'h3f);
                    write_reg(RegSpareB, 7'h00);
                end
                4: set_gains(7'd2, 7'd2);
                5: set_gains(7'($urandom_range(0, 64)), 7'($urandom_range(0, 20)));
                default: set_gains(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
            random_runs(PhaseItems);
        end

        // Drain, release the receiver, then keep watching for strays.
        pause_sender(1);
        wait_drained();
        draining = 1'b1;
        repeat (PipeDepth * 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending_firing.size() == 0)
            $display("[pi_phase_angle_controller] OK");
        else
            $display("[pi_phase_angle_controller] ERROR");
        $finish;
    end

endmodule
